@@ rtl/dense_layer_sigmoid_core_macros.svh @@
// Assertion macros for the dense layer core RTL.
`ifndef DENSE_LAYER_SIGMOID_CORE_MACROS_SVH
`define DENSE_LAYER_SIGMOID_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define DLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define DLS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DLS_ASSERT_IMP(lbl, ante, cons, msg)
`define DLS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/dls_pkg.sv @@
// Types, codes and the logistic approximation for the dense layer core.
`default_nettype none

package dls_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD_INPUT  = 2'd0,
		ACT_LOAD_WEIGHT = 2'd1,
		ACT_EVALUATE    = 2'd2
	} dls_action_t;

	localparam logic CFG_INPUT_COUNT  = 1'b0;
	localparam logic CFG_NEURON_COUNT = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_MAC   = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_SAT   = 6'b010000,
		ST_OUT   = 6'b100000
	} dls_state_t;

	// Piecewise linear logistic of a Q16.16 value, result in Q0.16.
	function automatic logic [15:0] dls_logistic(input logic [31:0] act);
		logic [31:0] mag;
		logic [16:0] y;
		logic [16:0] neg;
		mag = act[31] ? (~act + 32'd1) : act;
		if (mag < 32'd65536) begin
			y = 17'(mag >> 2) + 17'd32768;
		end else if (mag < 32'd155648) begin
			y = 17'(mag >> 3) + 17'd40960;
		end else if (mag < 32'd327680) begin
			y = 17'(mag >> 5) + 17'd55296;
		end else begin
			y = 17'd65536;
		end
		neg = 17'd65536 - y;
		if (!act[31]) begin
			return y[16] ? 16'hFFFF : y[15:0];
		end
		return neg[15:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/dls_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module dls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/dense_layer_sigmoid_core.sv @@
// Top level of the fully connected layer core with logistic output.
`default_nettype none
`include "dense_layer_sigmoid_core_macros.svh"

// The slave stream carries requests: tuser holds the action, tdata holds the
// neuron index, the input index and a Q8.8 value. A load request writes one
// input element or one weight if its indices are in range. An evaluate
// request walks every neuron in use and sends one result per neuron on the
// master stream, neuron number, Q16.16 activation and Q0.16 logistic value,
// with tlast on the final neuron. The walk does one multiply-accumulate per
// cycle through the single read port of each memory, and no request is
// taken while an evaluate request runs. After reset both memories are
// cleared, one entry per cycle, in a pass over MAX_NEURONS * MAX_INPUTS
// weight addresses (1024 at the defaults); tready stays low until that pass
// ends. Configuration writes are taken at any time. A result waits in the
// output register while the receiver stalls; the walk goes on with the next
// neuron and then holds until the output register is free.
module dense_layer_sigmoid_core import dls_pkg::*; #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_NEURONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: neuron_index[3:0], input_index[9:4], value[25:10], zero pad.
	input  wire logic [31:0] s_tdata,
	// tuser: action[1:0].
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: neuron_number[3:0], activation[35:4], squashed[51:36], zero pad.
	output logic [55:0]      m_tdata,
	output logic             m_tlast
);

	localparam int IAW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int ACCW   = 33 + $clog2(MAX_INPUTS);
	localparam int NIN_MAX  = (MAX_INPUTS < 127) ? MAX_INPUTS : 127;
	localparam int NOUT_MAX = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;

	dls_state_t state_q;

	logic [6:0]  cfg_input_count_q;
	logic [4:0]  cfg_neuron_count_q;
	logic [WAW-1:0] clr_q;
	logic [6:0]  n_in_q;
	logic [4:0]  n_out_q;
	logic [6:0]  i_q;
	logic [3:0]  n_q;
	logic [WAW-1:0] wbase_q;
	logic        v_s1;
	logic        v_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACCW-1:0] acc_q;
	logic [31:0] act_q;
	logic        out_valid_q;
	logic [3:0]  out_neuron_q;
	logic [31:0] out_act_q;
	logic [15:0] out_sq_q;
	logic        out_last_q;

	logic [1:0]  req_action;
	logic [3:0]  req_nidx;
	logic [5:0]  req_iidx;
	logic [15:0] req_value;
	logic        accept;
	logic        idx_ok;
	logic        nidx_ok;
	logic        load_in;
	logic        load_w;
	logic        clearing;
	logic [6:0]  n_in_eff;
	logic [4:0]  n_out_eff;
	logic        issue;
	logic        out_free;
	logic        out_load;
	logic        cur_last;
	logic [31:0] sat_act;
	logic [31:0] iidx_ext;
	logic [31:0] clr_ext;
	logic [31:0] i_ext;
	logic [31:0] wload_addr;

	logic           in_we;
	logic [IAW-1:0] in_waddr;
	logic [15:0]    in_wdata;
	logic [IAW-1:0] in_raddr;
	logic [15:0]    in_rdata;
	logic           w_we;
	logic [WAW-1:0] w_waddr;
	logic [15:0]    w_wdata;
	logic [WAW-1:0] w_raddr;
	logic [15:0]    w_rdata;

	assign req_action = s_tuser;
	assign req_nidx   = s_tdata[3:0];
	assign req_iidx   = s_tdata[9:4];
	assign req_value  = s_tdata[25:10];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign clearing = (state_q == ST_CLEAR);

	assign iidx_ext   = 32'(req_iidx);
	assign clr_ext    = 32'(clr_q);
	assign i_ext      = 32'(i_q);
	assign idx_ok     = (iidx_ext < 32'(MAX_INPUTS));
	assign nidx_ok    = (32'(req_nidx) < 32'(MAX_NEURONS));
	assign wload_addr = 32'(req_nidx) * 32'(MAX_INPUTS) + iidx_ext;

	always_comb begin
		load_in = 1'b0;
		load_w  = 1'b0;
		case (req_action)
			ACT_LOAD_INPUT:  load_in = accept && idx_ok;
			ACT_LOAD_WEIGHT: load_w  = accept && idx_ok && nidx_ok;
			default: begin
				load_in = 1'b0;
				load_w  = 1'b0;
			end
		endcase
	end

	assign n_in_eff  = (32'(cfg_input_count_q) > 32'(NIN_MAX)) ?
		7'(NIN_MAX) : cfg_input_count_q;
	assign n_out_eff = (32'(cfg_neuron_count_q) > 32'(NOUT_MAX)) ?
		5'(NOUT_MAX) : cfg_neuron_count_q;

	assign in_we    = clearing ? (clr_ext < 32'(MAX_INPUTS)) : load_in;
	assign in_waddr = clearing ? clr_ext[IAW-1:0] : iidx_ext[IAW-1:0];
	assign in_wdata = clearing ? 16'd0 : req_value;
	assign in_raddr = i_ext[IAW-1:0];

	assign w_we    = clearing || load_w;
	assign w_waddr = clearing ? clr_q : wload_addr[WAW-1:0];
	assign w_wdata = clearing ? 16'd0 : req_value;
	assign w_raddr = WAW'(32'(wbase_q) + i_ext);

	dls_ram #(
		.WIDTH(16),
		.DEPTH(MAX_INPUTS)
	) u_input_ram (
		.clk(clk),
		.we(in_we),
		.waddr(in_waddr),
		.wdata(in_wdata),
		.raddr(in_raddr),
		.rdata(in_rdata)
	);

	dls_ram #(
		.WIDTH(16),
		.DEPTH(WDEPTH)
	) u_weight_ram (
		.clk(clk),
		.we(w_we),
		.waddr(w_waddr),
		.wdata(w_wdata),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	assign issue    = (state_q == ST_MAC) && (i_q != n_in_q);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign cur_last = ((5'(n_q) + 5'd1) == n_out_q);

	always_comb begin
		if ((&acc_q[ACCW-1:31]) || !(|acc_q[ACCW-1:31])) begin
			sat_act = acc_q[31:0];
		end else if (acc_q[ACCW-1]) begin
			sat_act = 32'h8000_0000;
		end else begin
			sat_act = 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_input_count_q  <= 7'd1;
			cfg_neuron_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INPUT_COUNT:  cfg_input_count_q  <= cfg_wdata;
				CFG_NEURON_COUNT: cfg_neuron_count_q <= cfg_wdata[4:0];
				default: cfg_input_count_q <= cfg_input_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_in_q      <= '0;
			n_out_q     <= '0;
			i_q         <= '0;
			n_q         <= '0;
			wbase_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WAW'(WDEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (req_action == ACT_EVALUATE) && (n_out_eff != 5'd0)) begin
						n_in_q  <= n_in_eff;
						n_out_q <= n_out_eff;
						i_q     <= '0;
						n_q     <= '0;
						wbase_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (i_q == n_in_q) begin
						state_q <= ST_DRAIN;
					end else begin
						i_q <= i_q + 7'd1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (cur_last) begin
							state_q <= ST_IDLE;
						end else begin
							n_q     <= n_q + 4'd1;
							wbase_q <= WAW'(32'(wbase_q) + 32'(MAX_INPUTS));
							i_q     <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(in_rdata) * $signed(w_rdata);
		if ((state_q == ST_IDLE) || (state_q == ST_SAT)) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACCW - 32){prod_s2[31]}}, prod_s2};
		end
		if (state_q == ST_SAT) begin
			act_q <= sat_act;
		end
		if (out_load) begin
			out_neuron_q <= n_q;
			out_act_q    <= act_q;
			out_sq_q     <= dls_logistic(act_q);
			out_last_q   <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_sq_q, out_act_q, out_neuron_q};
	assign m_tlast  = out_last_q;

	`DLS_ASSERT_IMP(a_read_only_in_mac, v_s1, $past(state_q) == ST_MAC, "read outside MAC walk")
	`DLS_ASSERT_IMP(a_product_follows_read, v_s2, $past(v_s1), "product without a read")
	`DLS_ASSERT_IMP(a_index_in_range, state_q == ST_MAC, i_q <= n_in_q, "input index overran count")
	`DLS_ASSERT_NXT(a_last_ends_walk, out_load && cur_last, state_q == ST_IDLE, "walk continued after last")

endmodule

`default_nettype wire
